@@ src/hcsd_pkg.sv @@
// ----------------------------------------------------------------------------
// hcsd_pkg: shared types and constants of the HSV segmentation block
// Register codes, channel field widths and the per-pixel mask records.
// ----------------------------------------------------------------------------
package hcsd_pkg;

   localparam int PixW  = 8;
   localparam int CsrW  = 16;
   localparam int DimW  = 12;
   localparam int RowW  = 11;
   localparam int IdxW  = 3;

   typedef enum logic [IdxW-1:0] {
      CSR_WHITE_LIMITS = 3'd0,
      CSR_RED_BAND     = 3'd1,
      CSR_BLUE_BAND    = 3'd2,
      CSR_GREEN_BAND   = 3'd3,
      CSR_VALUE_BAND   = 3'd4,
      CSR_IMAGE_WIDTH  = 3'd5,
      CSR_IMAGE_HEIGHT = 3'd6
   } csr_index_type;

   // Classification of one pixel.
   typedef struct packed {
      logic object;
      logic green;
      logic white;
   } mask_type;

   // One column of vertically combined masks in the horizontal window.
   typedef struct packed {
      logic col0;
      logic white;
      logic green;
      logic object;
   } tap_type;

endpackage

@@ src/hcsd_req_if.sv @@
// ----------------------------------------------------------------------------
// hcsd_req_if: pixel input channel
// Valid/ready channel carrying one HSV pixel or a flush marker per beat.
// ----------------------------------------------------------------------------
interface hcsd_req_if import hcsd_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [PixW-1:0] hue;
   logic [PixW-1:0] saturation;
   logic [PixW-1:0] brightness;
   logic            flush;

   modport source (output valid, hue, saturation, brightness, flush, input ready);
   modport sink   (input valid, hue, saturation, brightness, flush, output ready);
endinterface

@@ src/hcsd_rsp_if.sv @@
// ----------------------------------------------------------------------------
// hcsd_rsp_if: segmentation result channel
// Valid/ready channel carrying one classified pixel position per beat.
// ----------------------------------------------------------------------------
interface hcsd_rsp_if import hcsd_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [RowW-1:0] out_row;
   logic [RowW-1:0] out_col;
   logic            colored_object;
   logic            frame_done;

   modport source (output valid, out_row, out_col, colored_object, frame_done,
                   input ready);
   modport sink   (input valid, out_row, out_col, colored_object, frame_done,
                   output ready);
endinterface

@@ src/hsv_color_segment_dilate.sv @@
// ----------------------------------------------------------------------------
// hsv_color_segment_dilate: HSV band segmentation with white/green dilation
// Classifies raster pixels, dilates the white and green masks by square
// windows and reports red or blue in-band pixels clear of both.
// ----------------------------------------------------------------------------
// Throughput: one beat per clock on the input, stalled only by the output.
// Release: a result passes the stage one and result registers after the beat
// that releases it, which comes G rows and G columns after the pixel in raster
// order, G being the larger grow count. Column history is a one-port-pair RAM.
// Reset: synchronous; registers to defaults, geometry 640x480, no clearing pass.
module hsv_color_segment_dilate import hcsd_pkg::*; #(
   parameter int MAX_WIDTH  = 2048,
   parameter int WHITE_GROW = 6,
   parameter int GREEN_GROW = 4
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_wr_en,
   input  logic [IdxW-1:0] csr_index,
   input  logic [CsrW-1:0] csr_wdata,
   hcsd_req_if.sink        req_chan,
   hcsd_rsp_if.source      rsp_chan
);
   localparam int GMax     = (WHITE_GROW > GREEN_GROW) ? WHITE_GROW : GREEN_GROW;
   localparam int TapN     = 2 * GMax + 1;
   localparam int HistLen  = 2 * GMax + 2;
   localparam int HistW    = 3 * HistLen;
   localparam int DimLimit = (MAX_WIDTH < 2048) ? MAX_WIDTH : 2048;
   localparam int ColW     = $clog2(MAX_WIDTH);
   localparam int PreW     = $clog2(GMax * DimLimit + GMax + 2);

   // Configuration registers.
   logic [CsrW-1:0] white_limits_ff, red_band_ff, blue_band_ff;
   logic [CsrW-1:0] green_band_ff, value_band_ff;
   logic [DimW-1:0] image_width_ff, image_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         white_limits_ff <= '0;
         red_band_ff     <= '0;
         blue_band_ff    <= '0;
         green_band_ff   <= '0;
         value_band_ff   <= '0;
         image_width_ff  <= DimW'(640);
         image_height_ff <= DimW'(480);
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_WHITE_LIMITS: white_limits_ff <= csr_wdata;
            CSR_RED_BAND:     red_band_ff     <= csr_wdata;
            CSR_BLUE_BAND:    blue_band_ff    <= csr_wdata;
            CSR_GREEN_BAND:   green_band_ff   <= csr_wdata;
            CSR_VALUE_BAND:   value_band_ff   <= csr_wdata;
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_wdata[DimW-1:0];
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_wdata[DimW-1:0];
            default: begin
            end
         endcase
      end
   end

   function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v);
      logic [DimW-1:0] r;
      r = v;
      if (v == '0) r = DimW'(1);
      else if (v > DimW'(DimLimit)) r = DimW'(DimLimit);
      return r;
   endfunction

   // Frame position state.
   logic            active_ff;
   logic [DimW-1:0] w_ff, h_ff;
   logic [DimW-1:0] ri_ff;
   logic [ColW-1:0] ci_ff;
   logic [PreW-1:0] pre_ff;
   logic [RowW-1:0] orow_ff;
   logic [ColW-1:0] ocol_ff;

   // Stage one registers.
   logic            s1_valid_ff;
   mask_type        s1_mask_ff;
   logic [DimW-1:0] s1_row_ff;
   logic [ColW-1:0] s1_col_ff;
   logic            s1_emit_ff, s1_last_ff;
   logic [RowW-1:0] s1_orow_ff;
   logic [ColW-1:0] s1_ocol_ff;

   // Result register.
   logic            rsp_valid_ff;
   logic [RowW-1:0] rsp_row_ff, rsp_col_ff;
   logic            rsp_obj_ff, rsp_done_ff;

   logic out_free, s1_adv, accept;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign s1_adv   = s1_valid_ff && out_free;
   assign req_chan.ready = !s1_valid_ff || out_free;
   assign accept   = req_chan.valid && req_chan.ready;

   // Stage zero: position bookkeeping and classification.
   logic            start, active_cur, in_frame, step, emit, last;
   logic [DimW-1:0] w_cur, h_cur, ri_cur;
   logic [ColW-1:0] ci_cur, oc_cur;
   logic [RowW-1:0] or_cur;
   logic [PreW-1:0] pre_cur;
   mask_type        cls;

   always_comb begin
      start      = !active_ff && !req_chan.flush;
      active_cur = active_ff || start;
      w_cur      = start ? clamp_dim(image_width_ff)  : w_ff;
      h_cur      = start ? clamp_dim(image_height_ff) : h_ff;
      ri_cur     = start ? '0 : ri_ff;
      ci_cur     = start ? '0 : ci_ff;
      or_cur     = start ? '0 : orow_ff;
      oc_cur     = start ? '0 : ocol_ff;
      pre_cur    = start ? (PreW'(GMax) * PreW'(w_cur) + PreW'(GMax)) : pre_ff;
      in_frame   = ri_cur < h_cur;
      step       = active_cur && !(in_frame && req_chan.flush);
      emit       = pre_cur == '0;
      last       = emit && (DimW'(or_cur) == h_cur - DimW'(1))
                        && ((DimW + 1)'(oc_cur) == (DimW + 1)'(w_cur) - (DimW + 1)'(1));
      cls.white  = (req_chan.saturation < white_limits_ff[7:0])
                && (req_chan.brightness > white_limits_ff[15:8]);
      cls.green  = (req_chan.hue > green_band_ff[7:0]) && (req_chan.hue < green_band_ff[15:8]);
      cls.object = ((req_chan.hue < red_band_ff[7:0]) || (req_chan.hue > red_band_ff[15:8])
                 || ((req_chan.hue > blue_band_ff[7:0]) && (req_chan.hue < blue_band_ff[15:8])))
                && (req_chan.brightness > value_band_ff[7:0])
                && (req_chan.brightness < value_band_ff[15:8]);
      if (!in_frame) cls = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         w_ff      <= DimW'(640);
         h_ff      <= DimW'(480);
         ri_ff     <= '0;
         ci_ff     <= '0;
         pre_ff    <= '0;
         orow_ff   <= '0;
         ocol_ff   <= '0;
      end else if (accept && step) begin
         active_ff <= !last;
         w_ff      <= w_cur;
         h_ff      <= h_cur;
         pre_ff    <= emit ? '0 : pre_cur - PreW'(1);
         if (last) begin
            ri_ff   <= '0;
            ci_ff   <= '0;
            orow_ff <= '0;
            ocol_ff <= '0;
         end else begin
            if ((DimW + 1)'(ci_cur) + (DimW + 1)'(1) >= (DimW + 1)'(w_cur)) begin
               ci_ff <= '0;
               ri_ff <= ri_cur + DimW'(1);
            end else begin
               ci_ff <= ci_cur + ColW'(1);
               ri_ff <= ri_cur;
            end
            if (emit) begin
               if ((DimW + 1)'(oc_cur) + (DimW + 1)'(1) >= (DimW + 1)'(w_cur)) begin
                  ocol_ff <= '0;
                  orow_ff <= or_cur + RowW'(1);
               end else begin
                  ocol_ff <= oc_cur + ColW'(1);
                  orow_ff <= or_cur;
               end
            end else begin
               ocol_ff <= oc_cur;
               orow_ff <= or_cur;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= accept && step;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_chan.ready) begin
         s1_mask_ff <= cls;
         s1_row_ff  <= ri_cur;
         s1_col_ff  <= ci_cur;
         s1_emit_ff <= emit;
         s1_last_ff <= last;
         s1_orow_ff <= or_cur;
         s1_ocol_ff <= oc_cur;
      end
   end

   // Column history: each entry holds the last rows of the three mask bits.
   logic [HistW-1:0] hist_old, hist_new;

   hcsd_col_store #(
      .Depth (MAX_WIDTH),
      .DataW (HistW)
   ) u_col_store (
      .clock   (clock),
      .rd_en   (accept && step),
      .rd_addr (ci_cur),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data (hist_new),
      .rd_data (hist_old)
   );

   // Stage one: vertical combine, then horizontal window over the tap line.
   logic [HistLen-1:0] w_vec, g_vec, o_vec, row_ok;
   tap_type            entry;
   tap_type            line_ff [TapN];
   tap_type            line_nx [TapN];
   logic [TapN-1:0]    same;
   logic               dil_w, dil_g, hit;

   always_comb begin
      w_vec = {hist_old[HistLen-2:0], s1_mask_ff.white};
      g_vec = {hist_old[HistLen+HistLen-2:HistLen], s1_mask_ff.green};
      o_vec = {hist_old[3*HistLen-2:2*HistLen], s1_mask_ff.object};
      hist_new = {o_vec, g_vec, w_vec};
      // Slot k holds row (current row - k); rows above the frame are stale.
      for (int k = 0; k < HistLen; k++) begin
         row_ok[k] = DimW'(k) <= s1_row_ff;
      end
      entry.col0   = s1_col_ff == '0;
      entry.white  = 1'b0;
      entry.green  = 1'b0;
      entry.object = o_vec[GMax] & row_ok[GMax];
      for (int k = 0; k < HistLen; k++) begin
         if (k >= GMax - WHITE_GROW && k <= GMax + WHITE_GROW) begin
            entry.white = entry.white | (w_vec[k] & row_ok[k]);
         end
         if (k >= GMax - GREEN_GROW && k <= GMax + GREEN_GROW) begin
            entry.green = entry.green | (g_vec[k] & row_ok[k]);
         end
      end
   end

   always_comb begin
      line_nx[0] = entry;
      for (int j = 1; j < TapN; j++) begin
         line_nx[j] = line_ff[j-1];
      end
      // A tap shares the center's row unless a row start lies between them.
      same = '0;
      same[GMax] = 1'b1;
      for (int j = GMax - 1; j >= 0; j--) begin
         same[j] = same[j+1] && !line_nx[j].col0;
      end
      for (int j = GMax + 1; j < TapN; j++) begin
         same[j] = same[j-1] && !line_nx[j-1].col0;
      end
      dil_w = 1'b0;
      dil_g = 1'b0;
      for (int j = 0; j < TapN; j++) begin
         if (j >= GMax - WHITE_GROW && j <= GMax + WHITE_GROW) begin
            dil_w = dil_w | (line_nx[j].white & same[j]);
         end
         if (j >= GMax - GREEN_GROW && j <= GMax + GREEN_GROW) begin
            dil_g = dil_g | (line_nx[j].green & same[j]);
         end
      end
      hit = line_nx[GMax].object && !dil_w && !dil_g;
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         for (int j = 0; j < TapN; j++) begin
            line_ff[j] <= line_nx[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_adv && s1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_emit_ff) begin
         rsp_row_ff  <= s1_orow_ff;
         rsp_col_ff  <= RowW'(s1_ocol_ff);
         rsp_obj_ff  <= hit;
         rsp_done_ff <= s1_last_ff;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.out_row        = rsp_row_ff;
   assign rsp_chan.out_col        = rsp_col_ff;
   assign rsp_chan.colored_object = rsp_obj_ff;
   assign rsp_chan.frame_done     = rsp_done_ff;

   // A releasing beat that leaves stage one always shows up as a result.
   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      s1_adv && s1_emit_ff |=> rsp_chan.valid)
      else $error("released pixel did not reach the result register");

   // The beat that releases the last pixel of a frame closes the frame.
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      accept && step && last |=> !active_ff)
      else $error("frame still open after its last pixel");

   // The input column stays inside the latched width.
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> ((DimW + 1)'(ci_ff) < (DimW + 1)'(w_ff)))
      else $error("input column beyond image width");

   // The output row stays inside the latched height.
   a_row_range: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (DimW'(orow_ff) < h_ff))
      else $error("output row beyond image height");
endmodule

@@ src/hcsd_col_store.sv @@
// ----------------------------------------------------------------------------
// hcsd_col_store: per-column mask history memory
// One read and one write port, registered read data, with a bypass for a
// read that meets a write to the same column on the same edge.
// ----------------------------------------------------------------------------
module hcsd_col_store import hcsd_pkg::*; #(
   parameter int Depth = 2048,
   parameter int DataW = 42
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [DataW-1:0]         wr_data,
   output logic [DataW-1:0]         rd_data
);
   logic [DataW-1:0] mem [Depth];
   logic [DataW-1:0] rd_q_ff;
   logic [DataW-1:0] byp_data_ff;
   logic             byp_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff     <= mem[rd_addr];
         byp_ff      <= wr_en && (wr_addr == rd_addr);
         byp_data_ff <= wr_data;
      end
   end

   assign rd_data = byp_ff ? byp_data_ff : rd_q_ff;
endmodule

@@ sim/hcsd_seg_checker.sv @@
// ----------------------------------------------------------------------------
// hcsd_seg_checker: result predictor and comparator for the segmentation block
// Watches the register port and both channels, keeps its own copy of the
// mask line store and raster position, and compares every result beat.
// ----------------------------------------------------------------------------
module hcsd_seg_checker import hcsd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_wr_en,
   input  logic [IdxW-1:0] csr_index,
   input  logic [CsrW-1:0] csr_wdata,
   hcsd_req_if             req,
   hcsd_rsp_if             rsp,
   output int              fail_count,
   output int              pending
);
   localparam int WhiteGrow = 6;
   localparam int GreenGrow = 4;
   localparam int Reach     = 6;
   localparam int RingRows  = 2 * Reach + 2;
   localparam int DimLimit  = 2048;

   typedef struct {
      logic [RowW-1:0] row;
      logic [RowW-1:0] col;
      logic            obj;
      logic            done;
   } seg_result_type;

   seg_result_type  awaited[$];
   logic [CsrW-1:0] regs[7];
   logic [2:0]    mask_ring[RingRows][DimLimit];
   int unsigned   in_row, in_col, frame_w, frame_h;
   bit            busy;

   function automatic int unsigned clamp_dim(logic [DimW-1:0] d);
      if (d == 0) return 1;
      if (d > DimLimit) return DimLimit;
      return d;
   endfunction

   // OR of one mask bit over a square around (r, c), clipped to the frame.
   function automatic bit grown(int b, int g, int unsigned r, int unsigned c);
      int unsigned r0, r1, c0, c1;
      r0 = (r >= g) ? r - g : 0;
      c0 = (c >= g) ? c - g : 0;
      r1 = (r + g > frame_h - 1) ? frame_h - 1 : r + g;
      c1 = (c + g > frame_w - 1) ? frame_w - 1 : c + g;
      for (int unsigned y = r0; y <= r1; y++)
         for (int unsigned x = c0; x <= c1; x++)
            if (mask_ring[y % RingRows][x][b]) return 1;
      return 0;
   endfunction

   task automatic take_pixel(logic [7:0] hh, logic [7:0] ss, logic [7:0] vv, logic fl);
      int unsigned total, p, q, delay;
      bit wh, gr, rd, bl, va;
      seg_result_type e;
      if (!busy) begin
         if (fl) return;
         frame_w = clamp_dim(regs[CSR_IMAGE_WIDTH][DimW-1:0]);
         frame_h = clamp_dim(regs[CSR_IMAGE_HEIGHT][DimW-1:0]);
         in_row = 0;
         in_col = 0;
         busy = 1;
      end
      total = frame_w * frame_h;
      p = in_row * frame_w + in_col;
      if (p < total) begin
         // Flush beats inside the frame change nothing.
         if (fl) return;
         wh = ss < regs[CSR_WHITE_LIMITS][7:0] && vv > regs[CSR_WHITE_LIMITS][15:8];
         rd = hh < regs[CSR_RED_BAND][7:0] || hh > regs[CSR_RED_BAND][15:8];
         bl = hh > regs[CSR_BLUE_BAND][7:0] && hh < regs[CSR_BLUE_BAND][15:8];
         gr = hh > regs[CSR_GREEN_BAND][7:0] && hh < regs[CSR_GREEN_BAND][15:8];
         va = vv > regs[CSR_VALUE_BAND][7:0] && vv < regs[CSR_VALUE_BAND][15:8];
         mask_ring[in_row % RingRows][in_col] = {(rd | bl) & va, gr, wh};
      end
      delay = Reach * frame_w + Reach;
      if (p >= delay && p - delay < total) begin
         q = p - delay;
         e.row  = RowW'(q / frame_w);
         e.col  = RowW'(q % frame_w);
         e.obj  = mask_ring[(q / frame_w) % RingRows][q % frame_w][2]
                  & !grown(0, WhiteGrow, q / frame_w, q % frame_w)
                  & !grown(1, GreenGrow, q / frame_w, q % frame_w);
         e.done = (q == total - 1);
         awaited = {awaited, e};
         if (e.done) begin
            busy = 0;
            in_row = 0;
            in_col = 0;
            return;
         end
      end
      in_col++;
      if (in_col >= frame_w) begin
         in_col = 0;
         in_row++;
      end
   endtask

   task automatic check_result();
      seg_result_type e;
      if (awaited.size() == 0) begin
         $error("unexpected result row %0d col %0d", rsp.out_row, rsp.out_col);
         fail_count++;
         return;
      end
      e = awaited.pop_front();
      if (rsp.out_row !== e.row) begin
         $error("out_row expected %0d got %0d", e.row, rsp.out_row);
         fail_count++;
      end
      if (rsp.out_col !== e.col) begin
         $error("out_col expected %0d got %0d", e.col, rsp.out_col);
         fail_count++;
      end
      if (rsp.colored_object !== e.obj) begin
         $error("colored_object expected %0d got %0d", e.obj, rsp.colored_object);
         fail_count++;
      end
      if (rsp.frame_done !== e.done) begin
         $error("frame_done expected %0d got %0d", e.done, rsp.frame_done);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         fail_count = 0;
         foreach (regs[i]) regs[i] = '0;
         regs[CSR_IMAGE_WIDTH]  = 16'd640;
         regs[CSR_IMAGE_HEIGHT] = 16'd480;
         foreach (mask_ring[r, c]) mask_ring[r][c] = '0;
         awaited.delete();
         in_row = 0;
         in_col = 0;
         busy = 0;
         frame_w = 640;
         frame_h = 480;
      end else begin
         if (csr_wr_en && csr_index <= CSR_IMAGE_HEIGHT) regs[csr_index] = csr_wdata;
         if (req.valid && req.ready)
            take_pixel(req.hue, req.saturation, req.brightness, req.flush);
         if (rsp.valid && rsp.ready) check_result();
      end
      pending = awaited.size();
   end
endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for hsv_color_segment_dilate
// Runs frames of many geometries and thresholds through the block with
// random flushes and idling on both channels; the checker does the compare.
// ----------------------------------------------------------------------------
module tb;
   import hcsd_pkg::*;

   localparam int CycleLimit = 1000000;

   logic            clock = 0;
   logic            reset;
   logic            csr_wr_en;
   logic [IdxW-1:0] csr_index;
   logic [CsrW-1:0] csr_wdata;
   logic [CsrW-1:0] cfg[7];
   int              fail_count, pending;
   int              cycle = 0;
   int              pixel_count = 0;
   bit              calm;

   hcsd_req_if req ();
   hcsd_rsp_if rsp ();

   hsv_color_segment_dilate dut (
      .clock, .reset, .csr_wr_en, .csr_index, .csr_wdata,
      .req_chan(req), .rsp_chan(rsp)
   );

   hcsd_seg_checker checker_i (
      .clock, .reset, .csr_wr_en, .csr_index, .csr_wdata,
      .req(req), .rsp(rsp), .fail_count, .pending
   );

   always #5 clock = ~clock;

   assign calm = cycle >= 500 && cycle < 1500;

   always @(posedge clock) begin
      cycle <= cycle + 1;
      rsp.ready <= calm || ($urandom_range(99) >= 34);
      if (cycle >= CycleLimit) begin
         $display("tb: errors");
         $finish;
      end
   end

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(9))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic int clamp_dim(int d);
      return d < 1 ? 1 : (d > 2048 ? 2048 : d);
   endfunction

   // Waits for the beat to be taken; a random gap may come first.
   task automatic send(logic [7:0] hh, logic [7:0] ss, logic [7:0] vv, logic fl);
      if (!calm && $urandom_range(99) < 34) begin
         req.valid <= 0;
         do @(posedge clock); while (!calm && $urandom_range(99) < 34);
      end
      req.valid      <= 1;
      req.hue        <= hh;
      req.saturation <= ss;
      req.brightness <= vv;
      req.flush      <= fl;
      do @(posedge clock); while (!req.ready);
   endtask

   task automatic write_regs();
      for (int i = 0; i < 7; i++) begin
         csr_wr_en <= 1;
         csr_index <= IdxW'(i);
         csr_wdata <= cfg[i];
         @(posedge clock);
      end
      csr_wr_en <= 0;
   endtask

   // Thresholds that leave room for objects, or fully random ones.
   task automatic pick_bands(int wreg, int hreg);
      logic [7:0] g;
      g = $urandom_range(255);
      cfg[CSR_WHITE_LIMITS] = $urandom_range(2) == 0 ? 16'($urandom)
                              : {8'hF0 | 8'($urandom_range(15)), 8'($urandom_range(15))};
      cfg[CSR_RED_BAND]     = $urandom_range(2) == 0 ? 16'($urandom)
                              : {8'hC0 | 8'($urandom_range(63)), 8'($urandom_range(63))};
      cfg[CSR_BLUE_BAND]    = 16'($urandom);
      cfg[CSR_GREEN_BAND]   = $urandom_range(2) == 0 ? 16'($urandom)
                              : {g + 8'($urandom_range(6)), g};
      cfg[CSR_VALUE_BAND]   = $urandom_range(2) == 0 ? 16'($urandom) : 16'hF808;
      cfg[CSR_IMAGE_WIDTH]  = 16'(wreg);
      cfg[CSR_IMAGE_HEIGHT] = 16'(hreg);
   endtask

   // One whole frame: at times a flush before it, pixels with stray flushes, then the
   // drain, where pixel beats count as flushes.
   task automatic run_frame(int wreg, int hreg);
      int w, h;
      w = clamp_dim(wreg);
      h = clamp_dim(hreg);
      write_regs();
      if ($urandom_range(3) == 0) send(pick_byte(), pick_byte(), pick_byte(), 1);
      for (int i = 0; i < w * h; i++) begin
         if ($urandom_range(9) == 0) send(pick_byte(), pick_byte(), pick_byte(), 1);
         send(pick_byte(), pick_byte(), pick_byte(), 0);
      end
      for (int i = 0; i < 6 * w + 6; i++)
         send(pick_byte(), pick_byte(), pick_byte(), 1'($urandom_range(1)));
      if ($urandom_range(2) == 0) send(pick_byte(), pick_byte(), pick_byte(), 1);
      req.valid <= 0;
      pixel_count += w * h + 6 * w + 6;
      @(posedge clock);
      wait (pending == 0);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      reset      <= 1;
      csr_wr_en  <= 0;
      csr_index  <= '0;
      csr_wdata  <= '0;
      req.valid  <= 0;
      req.hue    <= '0;
      req.saturation <= '0;
      req.brightness <= '0;
      req.flush  <= 0;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (cfg[i]) cfg[i] = 16'h0000;
      run_frame(0, 0);
      // Saturated thresholds; the geometry registers keep only their low bits.
      foreach (cfg[i]) cfg[i] = 16'hFFFF;
      cfg[CSR_IMAGE_WIDTH]  = 16'hF010;
      cfg[CSR_IMAGE_HEIGHT] = 16'hF001;
      run_frame(16, 1);
      pick_bands(13, 13);
      run_frame(13, 13);

      while (pixel_count < 1600) begin
         pick_bands($urandom_range(1, 16), $urandom_range(1, 8));
         run_frame(cfg[CSR_IMAGE_WIDTH], cfg[CSR_IMAGE_HEIGHT]);
      end

      wait (pending == 0);
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end
endmodule

@@ files.f @@
src/hcsd_pkg.sv
src/hcsd_req_if.sv
src/hcsd_rsp_if.sv
src/hcsd_col_store.sv
src/hsv_color_segment_dilate.sv
sim/hcsd_seg_checker.sv
sim/tb.sv
